>>> rtl/bdq_pkg.sv
// shared constants and types of the bounded deque with search
// no dependencies
package bdq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = IDX_W + 1;
	localparam int DATA_W   = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;
	localparam logic [2:0] OP_REVERSE    = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

>>> rtl/bdq_store.sv
// entry storage of the deque: one write port, one registered read port
// depends on bdq_pkg
module bdq_store
	import bdq_pkg::*;
(
	input  logic              clk,
	input  wr_req_t           wr,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/bounded_deque_with_search_unit.sv
// top level of the bounded deque with search: op decode, ring pointers, search sequencer
// depends on bdq_pkg and bdq_store
//
// usage:
//   input beats carry an operation in s_axis_tuser and a signed 32-bit value in
//   s_axis_tdata; each accepted beat yields exactly one result beat on m_axis.
//   push, pop, reverse and unused codes finish in the cycle of acceptance: the
//   result is valid on the next cycle.
//   a search on n held entries walks the ring one entry per cycle through the
//   single read port of the entry memory and one shared 32-bit comparator; the
//   result is registered once the last entry has been compared.
//   while a search runs, s_axis_tready is low.
//   the result sits in an output register; a new beat is taken while that
//   register is empty or being drained in the same cycle, so a stalled receiver
//   holds the result and stops input after one pending result.
//   reset (arst_n low) empties the deque, clears the direction flag and drops
//   any pending result; no clearing pass is needed since only live entries are
//   ever read.
module bounded_deque_with_search_unit
	import bdq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value[31:0]
	input  logic [2:0]  s_axis_tuser,   // op[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // status[1:0], found[2], entry_count[7:3]
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] x);
		return (x == IDX_W'(CAPACITY - 1)) ? '0 : x + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] x);
		return (x == '0) ? IDX_W'(CAPACITY - 1) : x - IDX_W'(1);
	endfunction

	logic                     state_q;
	logic [IDX_W-1:0]         first_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     rev_q;
	logic [IDX_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         left_q;
	logic                     hit_q;
	logic signed [DATA_W-1:0] key_q;
	logic                     cmp_vld_s1;
	logic                     m_valid_q;
	logic [1:0]               status_q;
	logic                     found_q;
	logic [4:0]               count_q;

	logic                     acc;
	logic                     phys_back;
	logic [SUM_W-1:0]         back_sum;
	logic [IDX_W-1:0]         back_idx;
	logic [IDX_W-1:0]         first_dec;
	logic [IDX_W-1:0]         first_inc;
	wr_req_t                  wr;
	logic [IDX_W-1:0]         nxt_first;
	logic [CNT_W-1:0]         nxt_cnt;
	logic                     nxt_rev;
	logic [1:0]               res_status;
	logic                     start_scan;
	logic                     issue;
	logic                     scan_done;
	logic signed [DATA_W-1:0] rd_data;

	assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {count_q, found_q, status_q};

	assign phys_back = ((s_axis_tuser == OP_PUSH_BACK) || (s_axis_tuser == OP_POP_BACK)) ^ rev_q;
	assign back_sum  = SUM_W'(first_q) + SUM_W'(cnt_q);
	assign back_idx  = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
	                                                  : IDX_W'(back_sum);
	assign first_dec = ring_dec(first_q);
	assign first_inc = ring_inc(first_q);

	assign issue     = (state_q == ST_SCAN) && (left_q != '0);
	assign scan_done = (state_q == ST_SCAN) && (left_q == '0) && !cmp_vld_s1;

	always_comb begin
		wr         = '0;
		wr.data    = s_axis_tdata;
		nxt_first  = first_q;
		nxt_cnt    = cnt_q;
		nxt_rev    = rev_q;
		res_status = ST_OK;
		start_scan = 1'b0;
		unique case (s_axis_tuser)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					res_status = ST_FULL;
				end else begin
					wr.en   = acc;
					nxt_cnt = cnt_q + CNT_W'(1);
					if (phys_back) begin
						wr.addr = back_idx;
					end else begin
						wr.addr   = first_dec;
						nxt_first = first_dec;
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (cnt_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					nxt_cnt = cnt_q - CNT_W'(1);
					if (!phys_back) begin
						nxt_first = first_inc;
					end
				end
			end
			OP_SEARCH: begin
				start_scan = (cnt_q != '0);
			end
			OP_REVERSE: begin
				nxt_rev = ~rev_q;
			end
			default: begin
			end
		endcase
	end

	bdq_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			first_q    <= '0;
			cnt_q      <= '0;
			rev_q      <= 1'b0;
			ptr_q      <= '0;
			left_q     <= '0;
			hit_q      <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (acc) begin
				first_q <= nxt_first;
				cnt_q   <= nxt_cnt;
				rev_q   <= nxt_rev;
				if (start_scan) begin
					state_q <= ST_SCAN;
					ptr_q   <= first_q;
					left_q  <= cnt_q;
					hit_q   <= 1'b0;
				end else begin
					m_valid_q <= 1'b1;
				end
			end
			if (issue) begin
				ptr_q  <= ring_inc(ptr_q);
				left_q <= left_q - CNT_W'(1);
			end
			if (cmp_vld_s1 && (rd_data == key_q)) begin
				hit_q <= 1'b1;
			end
			if (scan_done) begin
				state_q   <= ST_IDLE;
				m_valid_q <= 1'b1;
			end
		end
	end

	// result payload and search key
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q    <= s_axis_tdata;
			status_q <= res_status;
			found_q  <= 1'b0;
			count_q  <= 5'(nxt_cnt);
		end
		if (scan_done) begin
			status_q <= ST_OK;
			found_q  <= hit_q;
			count_q  <= 5'(cnt_q);
		end
	end

endmodule
